// File: hw/rtl/bitmap_first_fit_block_allocator_assert.svh
// Assertion macros for the allocator RTL, included by bffa_back.
// Each macro checks on the rising edge of clock and is off while reset is high.
// Define NO_ASSERTIONS to compile every check away.
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define BFFA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define BFFA_ASSERT_SAME(lbl, ante, cons, msg)
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/bffa_pkg.sv
// Shared types and constants for the bitmap first-fit block allocator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bffa_pkg;

   // field widths of the stream payloads
   localparam int unsigned CMD_W      = 1;
   localparam int unsigned SIZE_W     = 14;
   localparam int unsigned START_W    = 9;
   localparam int unsigned COUNT_W    = 10;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 24;
   localparam int unsigned REQ_PAD_W  = REQ_DATA_W - SIZE_W - START_W - COUNT_W;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - START_W - COUNT_W;

   // wide enough for any block number or start+count sum (map up to 4096)
   localparam int unsigned CMP_W    = 13;
   // ceil(size/16) + BLOCK_SIZE - 1 stays below 2048
   localparam int unsigned NUM_W    = 11;
   // block count of an allocate, at most 1024
   localparam int unsigned NEED_W   = 11;
   // reciprocal scaling for the divide by BLOCK_SIZE
   localparam int unsigned RECIP_SH = 19;
   localparam int unsigned RECIP_W  = RECIP_SH + 1;

   // map memory row: 8 blocks per word
   localparam int unsigned ROW_BITS = 8;
   localparam int unsigned ROW_SH   = 3;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED  = 2'd0,
      ST_NO_SPACE   = 2'd1,
      ST_FREED      = 2'd2,
      ST_FREE_RANGE = 2'd3
   } status_type;

   // job kinds after classification in the front end
   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_FREE_BAD = 2'd2
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [NEED_W-1:0]    need;
      logic [START_W-1:0]   start;
      logic [COUNT_W-1:0]   count;
   } job_type;

   typedef enum logic [2:0] {
      BK_CLEAR  = 3'd0,
      BK_IDLE   = 3'd1,
      BK_SCAN   = 3'd2,
      BK_MOD_RD = 3'd3,
      BK_MOD_WR = 3'd4,
      BK_RESULT = 3'd5
   } back_state_type;

endpackage

// File: hw/rtl/bitmap_first_fit_block_allocator.sv
// Bitmap first-fit allocator: an occupancy map of NUM_BLOCKS blocks, held
// eight blocks to a memory row. After reset the engine clears the map row by
// row and starts no job until that sweep is done, though up to three request
// transactions are still accepted and held. Each job is picked up from the
// queue in the idle state, and its response register is loaded in the result
// state. An allocate scans the map one row per cycle from the memory read
// port until the first fitting run is found, then marks the run with a read
// and a write of each row it touches (at most 33 rows for the largest
// request). A free clears its run the same way; a rejected or empty free
// touches no row. The engine waits in its result state while an earlier
// response still waits on rsp_tready. Up to three requests wait in the front
// stage and job queue while the engine works.
// Depends on bffa_pkg, bffa_front, bffa_queue and bffa_back.
`timescale 1ns / 1ps

module bitmap_first_fit_block_allocator #(
   parameter int unsigned NUM_BLOCKS = 512,
   parameter int unsigned BLOCK_SIZE = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // request_size[13:0], start_block[22:14], block_count[32:23], zero pad
   input  logic [bffa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd[0]
   input  logic [bffa_pkg::CMD_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // alloc_start[8:0], alloc_count[18:9], zero pad
   output logic [bffa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status[1:0]
   output logic [bffa_pkg::STATUS_W-1:0]      rsp_tuser
);

   logic                fr_job_valid, fr_job_ready;
   bffa_pkg::job_type   fr_job;
   logic                bk_job_valid, bk_job_ready;
   bffa_pkg::job_type   bk_job;

   bffa_front #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (fr_job_valid),
      .job_ready  (fr_job_ready),
      .job        (fr_job)
   );

   bffa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_job_valid),
      .push_ready (fr_job_ready),
      .push_job   (fr_job),
      .pop_valid  (bk_job_valid),
      .pop_ready  (bk_job_ready),
      .pop_job    (bk_job)
   );

   bffa_back #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (bk_job_valid),
      .job_ready  (bk_job_ready),
      .job        (bk_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hw/rtl/bffa_front.sv
// Front end: takes request transactions, computes the block count of an
// allocate and range-checks a free. Depends on bffa_pkg.
`timescale 1ns / 1ps

module bffa_front #(
   parameter int unsigned NUM_BLOCKS = 512,
   parameter int unsigned BLOCK_SIZE = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // request_size, start_block, block_count, zero pad (low bit first)
   input  logic [bffa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  logic [bffa_pkg::CMD_W-1:0]         req_tuser,
   output logic                               job_valid,
   input  logic                               job_ready,
   output bffa_pkg::job_type                  job
);

   localparam int unsigned RECIP  = ((2 ** bffa_pkg::RECIP_SH) + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int unsigned PROD_W = bffa_pkg::NUM_W + bffa_pkg::RECIP_W;

   logic                               stg_vld_ff, stg_vld_in;
   bffa_pkg::cmd_type                  stg_cmd_ff;
   logic [bffa_pkg::NUM_W-1:0]         stg_num_ff;
   logic [bffa_pkg::START_W-1:0]       stg_start_ff;
   logic [bffa_pkg::COUNT_W-1:0]       stg_count_ff;

   logic [bffa_pkg::SIZE_W-1:0]        req_size;
   logic [bffa_pkg::START_W-1:0]       req_start;
   logic [bffa_pkg::COUNT_W-1:0]       req_count;
   logic [bffa_pkg::NUM_W-1:0]         num_in;
   logic                               req_take;
   logic [PROD_W-1:0]                  prod;
   logic [bffa_pkg::CMP_W-1:0]         free_end;

   // unpack the request payload
   assign req_size  = req_tdata[bffa_pkg::SIZE_W-1:0];
   assign req_start = req_tdata[bffa_pkg::SIZE_W+bffa_pkg::START_W-1:bffa_pkg::SIZE_W];
   assign req_count = req_tdata[bffa_pkg::SIZE_W+bffa_pkg::START_W+bffa_pkg::COUNT_W-1:
                                bffa_pkg::SIZE_W+bffa_pkg::START_W];

   // ceil(size/(16*B)) = ceil(ceil(size/16)/B); numerator for the divide by B
   assign num_in = bffa_pkg::NUM_W'((({1'b0, req_size}) + 15'd15) >> 4)
                 + bffa_pkg::NUM_W'(BLOCK_SIZE - 1);

   assign req_tready = !stg_vld_ff || job_ready;
   assign req_take   = req_tvalid && req_tready;
   assign stg_vld_in = req_take || (stg_vld_ff && !job_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
      end else begin
         stg_vld_ff <= stg_vld_in;
      end
   end

   // stage register, loaded on each accepted transaction
   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_cmd_ff   <= bffa_pkg::cmd_type'(req_tuser[0]);
         stg_num_ff   <= num_in;
         stg_start_ff <= req_start;
         stg_count_ff <= req_count;
      end
   end

   // divide by BLOCK_SIZE through an exact reciprocal multiply
   assign prod     = PROD_W'(stg_num_ff) * PROD_W'(RECIP);
   assign free_end = bffa_pkg::CMP_W'(stg_start_ff) + bffa_pkg::CMP_W'(stg_count_ff);

   // classify and hand the job to the queue
   always_comb begin
      job.need  = bffa_pkg::NEED_W'(prod >> bffa_pkg::RECIP_SH);
      job.start = stg_start_ff;
      job.count = stg_count_ff;
      if (stg_cmd_ff == bffa_pkg::CMD_ALLOC) begin
         job.op = bffa_pkg::OP_ALLOC;
      end else if (free_end > bffa_pkg::CMP_W'(NUM_BLOCKS)) begin
         job.op = bffa_pkg::OP_FREE_BAD;
      end else begin
         job.op = bffa_pkg::OP_FREE;
      end
   end

   assign job_valid = stg_vld_ff;

endmodule

// File: hw/rtl/bffa_queue.sv
// Short job queue between the front end and the map engine.
// Depends on bffa_pkg for the job type and depth.
`timescale 1ns / 1ps

module bffa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  bffa_pkg::job_type   push_job,
   output logic                pop_valid,
   input  logic                pop_ready,
   output bffa_pkg::job_type   pop_job
);

   localparam int unsigned PTR_W = $clog2(bffa_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(bffa_pkg::QUEUE_DEPTH + 1);

   bffa_pkg::job_type     entries_ff [bffa_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != CNT_W'(bffa_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: hw/rtl/bffa_back.sv
// Map engine: owns the occupancy memory, runs the first-fit scan, marks and
// clears runs, and holds the response register. Depends on bffa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bitmap_first_fit_block_allocator_assert.svh"

module bffa_back #(
   parameter int unsigned NUM_BLOCKS = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   output logic                               job_ready,
   input  bffa_pkg::job_type                  job,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // alloc_start, alloc_count, zero pad (low bit first)
   output logic [bffa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [bffa_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int unsigned NUM_ROWS = (NUM_BLOCKS + bffa_pkg::ROW_BITS - 1) / bffa_pkg::ROW_BITS;
   localparam int unsigned ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int unsigned BLK_W    = $clog2(NUM_BLOCKS);
   localparam int unsigned RUN_W    = $clog2(NUM_BLOCKS + 1);
   localparam logic [ROW_W-1:0]          LAST_ROW = ROW_W'(NUM_ROWS - 1);
   localparam logic [bffa_pkg::CMP_W-1:0] NUM_CMP = bffa_pkg::CMP_W'(NUM_BLOCKS);

   // occupancy memory, one bit per block
   logic [bffa_pkg::ROW_BITS-1:0]    map_mem [NUM_ROWS];

   bffa_pkg::back_state_type         state_ff, state_in;
   logic [ROW_W-1:0]                 row_ptr_ff, row_ptr_in;
   logic [ROW_W-1:0]                 last_row_ff, last_row_in;
   logic [ROW_W-1:0]                 scan_ptr_ff, scan_ptr_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic [ROW_W-1:0]                 rd_row_ff;
   logic [bffa_pkg::ROW_BITS-1:0]    rd_data_ff;
   logic [RUN_W-1:0]                 run_len_ff, run_len_in;
   logic [BLK_W-1:0]                 run_start_ff, run_start_in;
   logic [bffa_pkg::NEED_W-1:0]      need_ff, need_in;
   logic [BLK_W-1:0]                 lo_ff, lo_in;
   logic [BLK_W-1:0]                 hi_ff, hi_in;
   logic                             set_ff, set_in;
   bffa_pkg::status_type             res_status_ff, res_status_in;
   logic [BLK_W-1:0]                 res_start_ff, res_start_in;
   logic [bffa_pkg::NEED_W-1:0]      res_count_ff, res_count_in;
   logic                             out_vld_ff, out_vld_in;
   bffa_pkg::status_type             out_status_ff, out_status_in;
   logic [bffa_pkg::START_W-1:0]     out_start_ff, out_start_in;
   logic [bffa_pkg::COUNT_W-1:0]     out_count_ff, out_count_in;

   logic                             mem_we;
   logic [ROW_W-1:0]                 mem_wr_addr;
   logic [bffa_pkg::ROW_BITS-1:0]    mem_wr_data;
   logic [ROW_W-1:0]                 mem_rd_addr;

   logic                             scan_hit;
   logic [BLK_W-1:0]                 scan_hit_start;
   logic [RUN_W-1:0]                 scan_len;
   logic [BLK_W-1:0]                 scan_start;
   logic [bffa_pkg::ROW_BITS-1:0]    row_mask;
   logic [bffa_pkg::ROW_BITS-1:0]    mod_data;
   logic                             out_free;
   logic [BLK_W-1:0]                 free_hi;
   logic [BLK_W-1:0]                 alloc_hi;

   // map memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= map_mem[mem_rd_addr];
   end

   // first-fit step over one row: extend or restart the current free run
   always_comb begin
      logic [RUN_W-1:0]          len;
      logic [BLK_W-1:0]          st;
      logic [bffa_pkg::CMP_W-1:0] pos;
      logic                      used;
      len            = run_len_ff;
      st             = run_start_ff;
      scan_hit       = 1'b0;
      scan_hit_start = '0;
      for (int j = 0; j < bffa_pkg::ROW_BITS; j++) begin
         pos  = (bffa_pkg::CMP_W'(rd_row_ff) << bffa_pkg::ROW_SH) + bffa_pkg::CMP_W'(j);
         // blocks past the end of the map count as used
         used = rd_data_ff[j] || (pos >= NUM_CMP);
         if (!scan_hit) begin
            if (used) begin
               len = '0;
            end else begin
               if (len == '0) begin
                  st = BLK_W'(pos);
               end
               len = len + 1'b1;
               if (bffa_pkg::CMP_W'(len) >= bffa_pkg::CMP_W'(need_ff)) begin
                  scan_hit       = 1'b1;
                  scan_hit_start = st;
               end
            end
         end
      end
      scan_len   = len;
      scan_start = st;
   end

   // bits of the current row that fall inside [lo, hi]
   always_comb begin
      logic [bffa_pkg::CMP_W-1:0] pos;
      for (int b = 0; b < bffa_pkg::ROW_BITS; b++) begin
         pos = (bffa_pkg::CMP_W'(row_ptr_ff) << bffa_pkg::ROW_SH) + bffa_pkg::CMP_W'(b);
         row_mask[b] = (pos >= bffa_pkg::CMP_W'(lo_ff)) && (pos <= bffa_pkg::CMP_W'(hi_ff));
      end
   end

   assign mod_data = set_ff ? (rd_data_ff | row_mask) : (rd_data_ff & ~row_mask);
   assign out_free = !out_vld_ff || rsp_tready;
   assign free_hi  = BLK_W'(bffa_pkg::CMP_W'(job.start) + bffa_pkg::CMP_W'(job.count) - 1'b1);
   assign alloc_hi = BLK_W'(bffa_pkg::CMP_W'(scan_hit_start) + bffa_pkg::CMP_W'(need_ff) - 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bffa_pkg::BK_CLEAR: begin
            if (row_ptr_ff == LAST_ROW) begin
               state_in = bffa_pkg::BK_IDLE;
            end
         end
         bffa_pkg::BK_IDLE: begin
            if (job_valid) begin
               unique case (job.op)
                  bffa_pkg::OP_ALLOC: state_in = bffa_pkg::BK_SCAN;
                  bffa_pkg::OP_FREE: begin
                     state_in = (job.count == '0) ? bffa_pkg::BK_RESULT : bffa_pkg::BK_MOD_RD;
                  end
                  default: state_in = bffa_pkg::BK_RESULT;
               endcase
            end
         end
         bffa_pkg::BK_SCAN: begin
            if (rd_vld_ff) begin
               if (scan_hit) begin
                  state_in = (need_ff == '0) ? bffa_pkg::BK_RESULT : bffa_pkg::BK_MOD_RD;
               end else if (rd_row_ff == LAST_ROW) begin
                  state_in = bffa_pkg::BK_RESULT;
               end
            end
         end
         bffa_pkg::BK_MOD_RD: state_in = bffa_pkg::BK_MOD_WR;
         bffa_pkg::BK_MOD_WR: begin
            state_in = (row_ptr_ff == last_row_ff) ? bffa_pkg::BK_RESULT : bffa_pkg::BK_MOD_RD;
         end
         bffa_pkg::BK_RESULT: begin
            if (out_free) begin
               state_in = bffa_pkg::BK_IDLE;
            end
         end
         default: state_in = bffa_pkg::BK_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      row_ptr_in    = row_ptr_ff;
      last_row_in   = last_row_ff;
      scan_ptr_in   = scan_ptr_ff;
      rd_vld_in     = 1'b0;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      need_in       = need_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      set_in        = set_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_count_in  = res_count_ff;
      out_vld_in    = out_vld_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_start_in  = out_start_ff;
      out_count_in  = out_count_ff;
      job_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_wr_addr   = row_ptr_ff;
      mem_wr_data   = '0;
      mem_rd_addr   = row_ptr_ff;
      unique case (state_ff)
         bffa_pkg::BK_CLEAR: begin
            // post-reset sweep: every block free
            mem_we = 1'b1;
            if (row_ptr_ff != LAST_ROW) begin
               row_ptr_in = row_ptr_ff + 1'b1;
            end
         end
         bffa_pkg::BK_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               need_in      = job.need;
               res_start_in = '0;
               res_count_in = '0;
               unique case (job.op)
                  bffa_pkg::OP_ALLOC: begin
                     scan_ptr_in  = '0;
                     run_len_in   = '0;
                     run_start_in = '0;
                  end
                  bffa_pkg::OP_FREE: begin
                     res_status_in = bffa_pkg::ST_FREED;
                     lo_in         = BLK_W'(job.start);
                     hi_in         = free_hi;
                     row_ptr_in    = ROW_W'(BLK_W'(job.start) >> bffa_pkg::ROW_SH);
                     last_row_in   = ROW_W'(free_hi >> bffa_pkg::ROW_SH);
                     set_in        = 1'b0;
                  end
                  default: res_status_in = bffa_pkg::ST_FREE_RANGE;
               endcase
            end
         end
         bffa_pkg::BK_SCAN: begin
            // one row read issued per cycle, its data registered before the scan step uses it
            mem_rd_addr = scan_ptr_ff;
            rd_vld_in   = 1'b1;
            if (scan_ptr_ff != LAST_ROW) begin
               scan_ptr_in = scan_ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               run_len_in   = scan_len;
               run_start_in = scan_start;
               if (scan_hit) begin
                  res_status_in = bffa_pkg::ST_ALLOCATED;
                  res_start_in  = scan_hit_start;
                  res_count_in  = need_ff;
                  lo_in         = scan_hit_start;
                  hi_in         = alloc_hi;
                  row_ptr_in    = ROW_W'(scan_hit_start >> bffa_pkg::ROW_SH);
                  last_row_in   = ROW_W'(alloc_hi >> bffa_pkg::ROW_SH);
                  set_in        = 1'b1;
               end else if (rd_row_ff == LAST_ROW) begin
                  res_status_in = bffa_pkg::ST_NO_SPACE;
                  res_start_in  = '0;
                  res_count_in  = '0;
               end
            end
         end
         bffa_pkg::BK_MOD_RD: begin
            mem_rd_addr = row_ptr_ff;
         end
         bffa_pkg::BK_MOD_WR: begin
            // read-modify-write of one row
            mem_we      = 1'b1;
            mem_wr_data = mod_data;
            if (row_ptr_ff != last_row_ff) begin
               row_ptr_in = row_ptr_ff + 1'b1;
            end
         end
         bffa_pkg::BK_RESULT: begin
            if (out_free) begin
               out_vld_in    = 1'b1;
               out_status_in = res_status_ff;
               out_start_in  = bffa_pkg::START_W'(res_start_ff);
               out_count_in  = bffa_pkg::COUNT_W'(res_count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bffa_pkg::BK_CLEAR;
         row_ptr_ff <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_ptr_ff <= row_ptr_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      last_row_ff   <= last_row_in;
      scan_ptr_ff   <= scan_ptr_in;
      rd_row_ff     <= scan_ptr_ff;
      run_len_ff    <= run_len_in;
      run_start_ff  <= run_start_in;
      need_ff       <= need_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      set_ff        <= set_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_count_ff  <= res_count_in;
      out_status_ff <= out_status_in;
      out_start_ff  <= out_start_in;
      out_count_ff  <= out_count_in;
   end

   // response ports
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{bffa_pkg::RSP_PAD_W{1'b0}}, out_count_ff, out_start_ff};
   assign rsp_tuser  = out_status_ff;

   `BFFA_ASSERT_SAME(a_wr_after_rd, state_ff == bffa_pkg::BK_MOD_WR, $past(state_ff) == bffa_pkg::BK_MOD_RD, "row write without a preceding read")
   `BFFA_ASSERT_SAME(a_wr_row_range, state_ff == bffa_pkg::BK_MOD_WR, row_ptr_ff <= last_row_ff, "row write past the end of the run")
   `BFFA_ASSERT_SAME(a_rsp_from_result, $rose(out_vld_ff), $past(state_ff) == bffa_pkg::BK_RESULT, "response appeared outside the result step")

endmodule

// File: tb/bitmap_first_fit_block_allocator_test.sv
// Self-checking testbench for the bitmap first-fit block allocator.
// Keeps its own copy of the occupancy map to predict every response.
// Depends on bffa_pkg and bitmap_first_fit_block_allocator.
`timescale 1ns / 1ps

module bitmap_first_fit_block_allocator_test;

   localparam int NUM_BLOCKS     = 512;
   localparam int BLOCK_SIZE     = 4;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 150;
   localparam int WATCHDOG_LIMIT = 3000;

   // one response as the map predicts it
   typedef struct packed {
      bffa_pkg::status_type          status;
      logic [bffa_pkg::START_W-1:0]  run_start;
      logic [bffa_pkg::COUNT_W-1:0]  run_count;
   } outcome_type;

   // a run that is currently marked used
   typedef struct packed {
      logic [bffa_pkg::START_W-1:0]  base;
      logic [bffa_pkg::COUNT_W-1:0]  length;
   } run_type;

   logic clock;
   logic reset = 1'b1;

   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [bffa_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [bffa_pkg::CMD_W-1:0]        req_tuser  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [bffa_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic [bffa_pkg::STATUS_W-1:0]     rsp_tuser;

   // predicted occupancy and outstanding responses
   logic [NUM_BLOCKS-1:0]   block_used = '0;
   outcome_type             expected_outcomes[$];
   run_type                 live_runs[$];

   bit  sender_idle_on   = 1'b1;
   bit  receiver_idle_on = 1'b1;
   int  hold_request     = 0;
   int  hold_left        = 0;
   int  stall_left       = 0;
   int  quiet_cycles     = 0;
   int  error_count      = 0;
   int  items_sent       = 0;
   int  n_granted        = 0;
   int  n_no_space       = 0;
   int  n_freed          = 0;
   int  n_range          = 0;

   bitmap_first_fit_block_allocator #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .BLOCK_SIZE (BLOCK_SIZE)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Map model: first-fit allocate, range-checked free. Updates block_used.
   function automatic outcome_type predict_outcome(bffa_pkg::cmd_type cmd,
         logic [bffa_pkg::SIZE_W-1:0] size, logic [bffa_pkg::START_W-1:0] start,
         logic [bffa_pkg::COUNT_W-1:0] count);
      outcome_type res;
      int need, span, run, found;
      res.status    = bffa_pkg::ST_NO_SPACE;
      res.run_start = '0;
      res.run_count = '0;
      if (cmd == bffa_pkg::CMD_ALLOC) begin
         // block count rounds up; size carries four fraction bits
         need  = (int'(size) + 16 * BLOCK_SIZE - 1) / (16 * BLOCK_SIZE);
         span  = (need == 0) ? 1 : need;
         run   = 0;
         found = -1;
         for (int i = 0; i < NUM_BLOCKS && found < 0; i++) begin
            if (block_used[i]) begin
               run = 0;
            end else begin
               run++;
               if (run == span) found = i + 1 - span;
            end
         end
         if (found >= 0) begin
            for (int k = found; k < found + need; k++) block_used[k] = 1'b1;
            res.status    = bffa_pkg::ST_ALLOCATED;
            res.run_start = bffa_pkg::START_W'(found);
            res.run_count = bffa_pkg::COUNT_W'(need);
         end
      end else if (int'(start) + int'(count) > NUM_BLOCKS) begin
         res.status = bffa_pkg::ST_FREE_RANGE;
      end else begin
         for (int k = int'(start); k < int'(start) + int'(count); k++) block_used[k] = 1'b0;
         res.status = bffa_pkg::ST_FREED;
      end
      return res;
   endfunction

   // Offer one transaction, record its prediction, return once it is accepted.
   task automatic send_request(bffa_pkg::cmd_type cmd, logic [bffa_pkg::SIZE_W-1:0] size,
         logic [bffa_pkg::START_W-1:0] start, logic [bffa_pkg::COUNT_W-1:0] count);
      outcome_type outcome;
      if (sender_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      outcome = predict_outcome(cmd, size, start, count);
      expected_outcomes.insert(expected_outcomes.size(), outcome);
      if (outcome.status == bffa_pkg::ST_ALLOCATED && outcome.run_count != 0)
         live_runs.insert(live_runs.size(), {outcome.run_start, outcome.run_count});
      req_tvalid <= 1'b1;
      req_tdata  <= {{bffa_pkg::REQ_PAD_W{1'b0}}, count, start, size};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly small requests, some large, some zero, some anything
   function automatic logic [bffa_pkg::SIZE_W-1:0] random_size();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 2) return '0;
      if (pick < 15) return bffa_pkg::SIZE_W'($urandom_range(1, 1024));
      if (pick < 18) return bffa_pkg::SIZE_W'($urandom_range(1025, 16383));
      return bffa_pkg::SIZE_W'($urandom);
   endfunction

   // free one run that is still marked used, picked at random
   task automatic free_live_run();
      int idx;
      run_type r;
      idx = $urandom_range(0, live_runs.size() - 1);
      r   = live_runs[idx];
      live_runs.delete(idx);
      send_request(bffa_pkg::CMD_FREE, bffa_pkg::SIZE_W'($urandom), r.base, r.length);
   endtask

   // Corner cases: empty and full map, rounding, zero sizes, range edges.
   task automatic test_directed();
      send_request(bffa_pkg::CMD_ALLOC, 14'd0,     '1, '1);    // zero size on empty map
      send_request(bffa_pkg::CMD_ALLOC, 14'd1,     '0, '0);    // smallest size, one block
      send_request(bffa_pkg::CMD_ALLOC, 14'd64,    '1, '1);    // exactly one block
      send_request(bffa_pkg::CMD_ALLOC, 14'd65,    '0, '0);    // rounds up to two
      send_request(bffa_pkg::CMD_FREE,  '1,        9'd0, 10'd4);
      send_request(bffa_pkg::CMD_ALLOC, 14'd16383, '1, '1);    // largest request
      send_request(bffa_pkg::CMD_ALLOC, 14'd16383, '0, '0);    // map now full
      send_request(bffa_pkg::CMD_ALLOC, 14'd0,     '0, '0);    // zero size, nothing free
      send_request(bffa_pkg::CMD_ALLOC, 14'd1,     '1, '1);    // no space
      send_request(bffa_pkg::CMD_FREE,  '0,        9'd511, 10'd1);
      send_request(bffa_pkg::CMD_FREE,  '1,        9'd511, 10'd2);    // one past the end
      send_request(bffa_pkg::CMD_FREE,  '0,        9'd0, 10'd1023);   // widest count
      send_request(bffa_pkg::CMD_FREE,  '1,        9'd1, 10'd512);
      send_request(bffa_pkg::CMD_FREE,  '0,        9'd300, 10'd0);    // empty free
      send_request(bffa_pkg::CMD_FREE,  '1,        9'd100, 10'd10);
      send_request(bffa_pkg::CMD_ALLOC, 14'd0,     '1, '1);    // lowest free block
      send_request(bffa_pkg::CMD_ALLOC, 14'd641,   '0, '0);    // needs 11, hole is 10
      send_request(bffa_pkg::CMD_ALLOC, 14'd640,   '1, '1);    // fills the hole exactly
      send_request(bffa_pkg::CMD_FREE,  '0,        9'd0, 10'd512);    // whole map
      send_request(bffa_pkg::CMD_FREE,  '1,        9'd0, 10'd512);    // already free
      send_request(bffa_pkg::CMD_ALLOC, 14'd16320, '0, '0);
      send_request(bffa_pkg::CMD_ALLOC, 14'd15,    '1, '1);
      live_runs.delete();
   endtask

   // Mostly allocate/free pairs on live runs, plus raw and in-range frees.
   task automatic test_random_traffic(int n_items);
      int k, pick, span;
      logic [bffa_pkg::START_W-1:0] s;
      for (k = 0; k < n_items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 || (pick < 80 && live_runs.size() == 0)) begin
            send_request(bffa_pkg::CMD_ALLOC, random_size(), bffa_pkg::START_W'($urandom),
                         bffa_pkg::COUNT_W'($urandom));
         end else if (pick < 80) begin
            free_live_run();
         end else if (pick < 90) begin
            s    = bffa_pkg::START_W'($urandom);
            span = NUM_BLOCKS - int'(s);
            if ($urandom_range(0, 3) != 0 && span > 32) span = $urandom_range(0, 32);
            send_request(bffa_pkg::CMD_FREE, bffa_pkg::SIZE_W'($urandom), s,
                         bffa_pkg::COUNT_W'(span));
         end else begin
            send_request(bffa_pkg::CMD_FREE, bffa_pkg::SIZE_W'($urandom),
                         bffa_pkg::START_W'($urandom), bffa_pkg::COUNT_W'($urandom));
         end
      end
   endtask

   // Receiver holds off long enough for the input side to back up.
   task automatic test_output_stall();
      int k;
      hold_request = HOLD_CYCLES;
      for (k = 0; k < 12; k++) begin
         if (k % 3 == 2 && live_runs.size() != 0)
            free_live_run();
         else
            send_request(bffa_pkg::CMD_ALLOC, bffa_pkg::SIZE_W'($urandom_range(1, 512)),
                         '0, '0);
      end
      wait_for_drain();
   endtask

   // Response side: random stalls, plus the long hold-off when requested.
   always @(posedge clock) begin : receiver
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 11);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic compare_field(string what, int unsigned want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         error_count++;
      end
   endtask

   // Compare each response transaction with the oldest prediction.
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected response, expected none, got status %0d %s %0d %s %0d",
                     $time, rsp_tuser, "start", rsp_tdata[bffa_pkg::START_W-1:0],
                     "count", rsp_tdata[bffa_pkg::START_W +: bffa_pkg::COUNT_W]);
            error_count++;
         end else begin
            want = expected_outcomes.pop_front();
            compare_field("status", want.status, 16'(rsp_tuser));
            compare_field("alloc_start", want.run_start,
                          16'(rsp_tdata[bffa_pkg::START_W-1:0]));
            compare_field("alloc_count", want.run_count,
                          16'(rsp_tdata[bffa_pkg::START_W +: bffa_pkg::COUNT_W]));
            case (want.status)
               bffa_pkg::ST_ALLOCATED:  n_granted++;
               bffa_pkg::ST_NO_SPACE:   n_no_space++;
               bffa_pkg::ST_FREED:      n_freed++;
               default:                 n_range++;
            endcase
         end
      end
   end

   // Ends the run if no transaction moves on either side for too long.
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
                  $time, WATCHDOG_LIMIT, expected_outcomes.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(600);
      test_output_stall();
      // final stretch with no idling on either side
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      test_random_traffic(120);
      wait_for_drain();
      $display("Sent %0d requests: %0d allocations granted, %0d refused,",
               items_sent, n_granted, n_no_space);
      $display("%0d frees, %0d bad frees; full and empty maps and a %0d-cycle hold-off.",
               n_freed, n_range, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
